/* design/plpe_pkg.sv */
package plpe_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 6;
  localparam int unsigned PALETTE_SLOTS       = 16;
  localparam int unsigned SYMBOLS_PER_PIXEL   = 24;
  localparam int unsigned CNT_W               = 5;
  localparam int unsigned CFG_INDEX_W         = 3;
  localparam int unsigned CFG_DATA_W          = 16;

  localparam logic [23:0] DUMMY_COLOR = 24'hFFFFFF;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_T1_HI = 3'd0,
    REG_T1_LO = 3'd1,
    REG_T0_HI = 3'd2,
    REG_T0_LO = 3'd3,
    REG_GAP   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic        bit_value;
    logic [7:0]  high_time;
    logic [15:0] low_time;
    logic        last_symbol;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  t1_hi;
    logic [7:0]  t1_lo;
    logic [7:0]  t0_hi;
    logic [7:0]  t0_lo;
    logic [15:0] gap;
  } timing_t;

  // palette entries as 0xBBRRGG
  localparam logic [23:0] PALETTE [PALETTE_SLOTS] = '{
    24'h000000, 24'h000F00, 24'h00000F, 24'h0F0000, 24'h0F0F0F, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
  };

  // palette lookup with clamp, returned in green-red-blue wire order
  function automatic logic [23:0] wire_word(input logic [7:0] idx,
                                            input int unsigned entries);
    logic [23:0] c;
    c = DUMMY_COLOR;
    if ((32'(idx) < entries) && (32'(idx) < PALETTE_SLOTS)) begin
      c = PALETTE[idx[3:0]];
    end
    return {c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

/* design/plpe_cfg_regs.sv */
module plpe_cfg_regs
  import plpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output timing_t                timing
);

  timing_t timing_r, timing_nxt;

  assign cfg_ready = 1'b1;
  assign timing    = timing_r;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_T1_HI: timing_nxt.t1_hi = cfg_data[7:0];
        REG_T1_LO: timing_nxt.t1_lo = cfg_data[7:0];
        REG_T0_HI: timing_nxt.t0_hi = cfg_data[7:0];
        REG_T0_LO: timing_nxt.t0_lo = cfg_data[7:0];
        REG_GAP:   timing_nxt.gap   = cfg_data;
        default:   timing_nxt = timing_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r <= '{t1_hi: 8'd13, t1_lo: 8'd7, t0_hi: 8'd6,
                    t0_lo: 8'd14, gap: 16'd800};
    end else begin
      timing_r <= timing_nxt;
    end
  end

endmodule

/* design/plpe_serializer.sv */
module plpe_serializer
  import plpe_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  input  timing_t   timing,
  input  logic      sym_take,
  output logic      sym_valid,
  output out_beat_t sym
);

  logic [23:0]      word_r, word_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fe_r, fe_nxt;
  logic             busy_r, busy_nxt;
  logic             advance, done, accept, gap_sym;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SYMBOLS_PER_PIXEL - 1);
  localparam logic [CNT_W-1:0] GAP_SLOT = CNT_W'(SYMBOLS_PER_PIXEL);

  assign gap_sym = (cnt_r == GAP_SLOT);

  always_comb begin
    if (gap_sym) begin
      sym = '{bit_value: 1'b0, high_time: 8'd0, low_time: timing.gap,
              last_symbol: 1'b1};
    end else if (word_r[23]) begin
      sym = '{bit_value: 1'b1, high_time: timing.t1_hi,
              low_time: {8'd0, timing.t1_lo},
              last_symbol: !fe_r && (cnt_r == LAST_BIT)};
    end else begin
      sym = '{bit_value: 1'b0, high_time: timing.t0_hi,
              low_time: {8'd0, timing.t0_lo},
              last_symbol: !fe_r && (cnt_r == LAST_BIT)};
    end
  end

  assign sym_valid = busy_r;
  assign advance   = busy_r && sym_take;
  assign done      = advance && sym.last_symbol;
  assign in_stall  = busy_r && !done;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    fe_nxt   = fe_r;
    busy_nxt = busy_r;
    if (accept) begin
      word_nxt = wire_word(in_data.color_index, PALETTE_ENTRIES);
      cnt_nxt  = '0;
      fe_nxt   = in_data.frame_end;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (advance) begin
      word_nxt = {word_r[22:0], 1'b0};
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    fe_r   <= fe_nxt;
  end

endmodule

/* design/plpe_out_reg.sv */
module plpe_out_reg
  import plpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      sym_valid,
  output logic      sym_take,
  input  out_beat_t sym,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      valid_r, valid_nxt;
  out_beat_t data_r;

  assign sym_take  = !valid_r || !out_stall;
  assign valid_nxt = sym_take ? sym_valid : valid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_take && sym_valid) begin
      data_r <= sym;
    end
  end

endmodule

/* design/palette_led_pulse_encoder_unit.sv */
// a pixel accepted into the pixel register passes its first symbol beat on to the output register
// throughput: one symbol beat per cycle unless out_stall holds it, 24 beats per pixel, 25 with frame_end
// the bit counter of the pixel register counts those beats; the next pixel is taken
// in the cycle its predecessor's final symbol enters the output register
// reset: synchronous active-low rst_n empties both stages and loads default timings
module palette_led_pulse_encoder_unit
  import plpe_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  // symbol output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // timing registers, always ready for a write beat
  timing_t   timing;
  // symbol handed from the pixel register to the output register
  logic      sym_valid;
  logic      sym_take;
  out_beat_t sym;

  plpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  // holds the wire word of the pixel and walks it msb first; the gap
  // symbol follows the 24 data symbols when the pixel ends a frame
  plpe_serializer #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .timing    (timing),
    .sym_take  (sym_take),
    .sym_valid (sym_valid),
    .sym       (sym)
  );

  // result register, refilled whenever it is empty or being taken
  plpe_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (sym_valid),
    .sym_take  (sym_take),
    .sym       (sym),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/plpe_checker.sv */
module plpe_checker
  import plpe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input out_beat_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a pixel always yields more than one symbol, so the next is held off
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("pixel accepted right after another");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the gap symbol is always the final one of its pixel
  a_gap_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bit_value && out_data.high_time == 8'd0 &&
    out_data.low_time[15:8] != 8'd0 |-> out_data.last_symbol)
    else $error("gap symbol not marked last");

endmodule

bind palette_led_pulse_encoder_unit plpe_checker u_plpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import plpe_pkg::*;

  // palette size the block is built with, and its defined colors as 0xBBRRGG
  localparam int unsigned COLOR_COUNT = 6;
  localparam logic [23:0] COLOR_TABLE [COLOR_COUNT] = '{
    24'h000000, 24'h000F00, 24'h00000F, 24'h0F0000, 24'h0F0F0F, 24'hFFFFFF
  };
  localparam logic [23:0] CLAMP_COLOR   = 24'hFFFFFF;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 30;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  palette_led_pulse_encoder_unit #(
    .PALETTE_ENTRIES(COLOR_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // pixels waiting to be offered, and symbols predicted but not yet seen
  in_beat_t  pixel_backlog[$];
  out_beat_t pending_symbols[$];

  // local copy of the timing registers, tracks every accepted write
  timing_t line_timing = '{t1_hi: 8'd13, t1_lo: 8'd7, t0_hi: 8'd6,
                           t0_lo: 8'd14, gap: 16'd800};

  int unsigned pixels_queued   = 0;
  int unsigned pixels_taken    = 0;
  int unsigned symbols_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned mismatches      = 0;

  // 1 in gap_odds chance per cycle of an idle burst on each side, 0 turns idling off
  int unsigned gap_odds = 4;
  int unsigned send_gap_left = 0;
  int unsigned hold_left     = 0;
  logic        hold_req      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // pixel -> 24 symbol beats in green-red-blue order, msb first, plus latch gap at frame end
  task automatic encode_pixel(input in_beat_t px);
    logic [23:0] color;
    logic [23:0] grb;
    out_beat_t   sym;
    // out of range indexes fall back to the white clamp color
    color = (int'(px.color_index) < COLOR_COUNT) ? COLOR_TABLE[px.color_index[2:0]]
                                                 : CLAMP_COLOR;
    grb = {color[7:0], color[15:8], color[23:16]};
    for (int k = 23; k >= 0; k--) begin
      sym.bit_value   = grb[k];
      sym.high_time   = grb[k] ? line_timing.t1_hi : line_timing.t0_hi;
      sym.low_time    = grb[k] ? 16'(line_timing.t1_lo) : 16'(line_timing.t0_lo);
      // last flag moves to the gap symbol when the pixel closes a frame
      sym.last_symbol = (k == 0) && !px.frame_end;
      pending_symbols.push_back(sym);
    end
    if (px.frame_end) begin
      // latch gap: line held low, no high part
      sym.bit_value   = 1'b0;
      sym.high_time   = 8'd0;
      sym.low_time    = line_timing.gap;
      sym.last_symbol = 1'b1;
      pending_symbols.push_back(sym);
    end
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // input driver: holds a stalled beat, otherwise offers the next pixel or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      send_gap_left  = 0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap_left != 0) begin
        send_gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          // idle burst of random length
          send_gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          in_data  <= pixel_backlog.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: one long hold on request, else short random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      hold_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check the output beat first, then predict for an accepted pixel
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_symbols.size() == 0) begin
          $display("%0t ns: unexpected symbol beat, expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = pending_symbols.pop_front();
          compare_field("bit_value", 32'(want.bit_value), 32'(out_data.bit_value));
          compare_field("high_time", 32'(want.high_time), 32'(out_data.high_time));
          compare_field("low_time", 32'(want.low_time), 32'(out_data.low_time));
          compare_field("last_symbol", 32'(want.last_symbol),
                        32'(out_data.last_symbol));
          symbols_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        encode_pixel(in_data);
        pixels_taken++;
      end
    end
  end

  task automatic queue_pixel(input logic [7:0] idx, input logic fe);
    in_beat_t px;
    px.color_index = idx;
    px.frame_end   = fe;
    pixel_backlog.push_back(px);
    pixels_queued++;
  endtask

  // mostly palette and nearby indexes, some across the whole byte
  task automatic queue_random_pixels(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0)
        queue_pixel(8'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
      else
        queue_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // one register write beat, local timing copy follows the handshake
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_T1_HI: line_timing.t1_hi = value[7:0];
      REG_T1_LO: line_timing.t1_lo = value[7:0];
      REG_T0_HI: line_timing.t0_hi = value[7:0];
      REG_T0_LO: line_timing.t0_lo = value[7:0];
      REG_GAP:   line_timing.gap   = value;
      default: ;
    endcase
  endtask

  task automatic program_timing(input logic [15:0] one_hi, input logic [15:0] one_lo,
                                input logic [15:0] zero_hi, input logic [15:0] zero_lo,
                                input logic [15:0] gap);
    write_reg(REG_T1_HI, one_hi);
    write_reg(REG_T1_LO, one_lo);
    write_reg(REG_T0_HI, zero_hi);
    write_reg(REG_T0_LO, zero_lo);
    write_reg(REG_GAP, gap);
  endtask

  task automatic program_random_timing();
    program_timing(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                   16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                   16'($urandom_range(0, 16'hFFFF)));
  endtask

  // sender pause: all pixels taken and every predicted symbol seen
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || pending_symbols.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset timings: every palette entry, clamped indexes, frame ends
    gap_odds = 4;
    for (int i = 0; i < COLOR_COUNT; i++)
      queue_pixel(8'(i), 1'b0);
    queue_pixel(8'd6, 1'b0);
    queue_pixel(8'd7, 1'b0);
    queue_pixel(8'd15, 1'b1);
    queue_pixel(8'd16, 1'b0);
    queue_pixel(8'hAA, 1'b0);
    queue_pixel(8'h55, 1'b1);
    queue_pixel(8'hFF, 1'b1);
    queue_pixel(8'h00, 1'b1);
    wait_drained();

    // shortest timings and a zero latch gap; unmapped indexes must do nothing
    program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
    for (int i = int'(REG_GAP) + 1; i < (1 << CFG_INDEX_W); i++)
      write_reg(CFG_INDEX_W'(i), 16'($urandom_range(0, 16'hFFFF)));
    gap_odds = 3;
    for (int i = 0; i < COLOR_COUNT; i++)
      queue_pixel(8'(i), 1'b1);
    queue_random_pixels(40);
    wait_drained();

    // longest timings, upper data bits set on the byte registers
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gap_odds = 6;
    queue_random_pixels(40);
    // receiver stops for a long stretch while pixels keep coming
    @(posedge clk);
    hold_req <= 1'b1;
    wait_drained();

    // zero high and low times pass straight through
    program_timing(16'd0, 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 16'd0,
                   16'($urandom_range(0, 16'hFFFF)));
    gap_odds = 2;
    queue_random_pixels(40);
    wait_drained();

    // random register contents, varied idling
    for (int p = 0; p < 3; p++) begin
      program_random_timing();
      gap_odds = (p == 1) ? 0 : $urandom_range(2, 10);
      queue_random_pixels(45);
      wait_drained();
    end

    // closing stretch with no idling on either side
    program_random_timing();
    gap_odds = 0;
    queue_random_pixels(45);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels and %0d symbol beats over %0d register writes",
             pixels_taken, symbols_checked, reg_writes);
    $display("timing extremes, zero times and gap, clamped indexes, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/plpe_pkg.sv
design/plpe_cfg_regs.sv
design/plpe_serializer.sv
design/plpe_out_reg.sv
design/palette_led_pulse_encoder_unit.sv
design/plpe_checker.sv
bench/testbench.sv
